/* rtl/sha_pkg.sv */
// Shared types and constants for the SHA-256 message hasher.
// Holds the channel payload structs, the controller/datapath command and status
// structs, the state encoding, the round constants and the initial hash values.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       msg_last;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } sha_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_COMP,
        S_ADD,
        S_OUT
    } sha_state_t;

    typedef enum logic [1:0] {
        SEL_IN,
        SEL_80,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_en;
        logic      comp_start;
        logic      round_en;
        logic [5:0] round;
        logic      hash_add;
        logic      hash_init;
        logic [2:0] word_sel;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;
    } sha_status_t;

    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_START_POS = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD     = 3'd7;
    localparam logic [7:0] PAD_MARK      = 8'h80;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* rtl/sha256_message_hasher.sv */
// Top level of the SHA-256 message hasher.
// Depends on sha_pkg, sha_controller and sha_datapath.
//
// Usage:
//   s_ channel: one beat per message byte (data_byte, has_byte, msg_last).
//     A beat with has_byte low and msg_last high ends the message without a
//     byte, so an empty message is one such beat. has_byte low, msg_last low
//     is consumed and ignored.
//   m_ channel: eight beats per message, digest word 0 first, word_index
//     counting 0..7, digest_last on word 7.
// Intake: byte beats are accepted while the controller is idle; the beat that fills
//   a 64-byte block is followed by compression (64 rounds in the shared round
//   unit plus the chaining add), during which s_ready is low and no new byte is taken.
// Sequence: after the final beat, padding shifts one byte a cycle up to byte
//   63 of the block (plus one idle check at byte 56), then the block is compressed;
//   if fewer than nine bytes remained, an extra block is padded and compressed first.
//   The first digest beat is offered the cycle after the final chaining add.
// Stall: while digest beats wait, s_ready stays low and the words hold in
//   the chaining registers; after the last beat the block restarts from
//   the initial hash values. Reset (aresetn low, synchronous) clears the
//   controller, byte position and length and sets the chaining value to H_INIT at once.
module sha256_message_hasher import sha_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_payload
);

    sha_cmd_t    cmd;
    sha_status_t status;
    logic [31:0] digest_word;

    sha_controller u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .in_has_byte (s_payload.has_byte),
        .in_msg_last (s_payload.msg_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    sha_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_byte     (s_payload.data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

    // Drive the result beat straight from the chaining registers.
    assign m_payload.digest_word = digest_word;
    assign m_payload.word_index  = cmd.word_sel;
    assign m_payload.digest_last = (cmd.word_sel == LAST_WORD);

endmodule

/* rtl/sha_datapath.sv */
// SHA-256 datapath: block shift register with message schedule taps,
// working variables, chaining value, byte position and message length.
// Depends on sha_pkg; driven by sha_controller through sha_cmd_t.
module sha_datapath import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    input  logic [7:0]  in_byte,
    output sha_status_t status,
    output logic [31:0] digest_word
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [511:0] blk_reg;
    logic [31:0]  v_reg [8];
    logic [31:0]  h_reg [8];
    logic [5:0]   pos_reg;
    logic [60:0]  cnt_reg;

    logic [7:0]   byte_mux;
    logic [63:0]  len_bits;
    logic [2:0]   len_sel;
    logic [31:0]  w0, w1, w9, w14, w_new;
    logic [31:0]  t1, t2;
    logic [31:0]  sig0, sig1, bsig0, bsig1, ch, maj;

    // Message length in bits, sent big-endian at byte positions 56..63.
    assign len_bits = {cnt_reg, 3'b000};
    assign len_sel  = ~pos_reg[2:0];

    always_comb begin
        case (cmd.byte_sel)
            SEL_IN:   byte_mux = in_byte;
            SEL_80:   byte_mux = PAD_MARK;
            SEL_ZERO: byte_mux = 8'h00;
            SEL_LEN:  byte_mux = len_bits[{len_sel, 3'b000} +: 8];
            default:  byte_mux = 8'h00;
        endcase
    end

    // Schedule taps: word j of the window sits j words below the top of the shift line.
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];

    assign sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = sig1 + w9 + sig0 + w0;

    assign bsig1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign bsig0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + bsig1 + ch + K_TABLE[cmd.round] + w0;
    assign t2    = bsig0 + maj;

    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            blk_reg <= {blk_reg[503:0], byte_mux};
        end else if (cmd.round_en) begin
            blk_reg <= {blk_reg[479:0], w_new};
        end
        if (cmd.comp_start) begin
            v_reg <= h_reg;
        end else if (cmd.round_en) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg   <= H_INIT;
            pos_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.shift_en) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.hash_init) begin
                h_reg   <= H_INIT;
                cnt_reg <= '0;
            end else begin
                if (cmd.hash_add) begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                if (cmd.count_en) begin
                    cnt_reg <= cnt_reg + 61'd1;
                end
            end
        end
    end

    assign status.byte_pos = pos_reg;
    assign digest_word     = h_reg[cmd.word_sel];

endmodule

/* rtl/sha_controller.sv */
// SHA-256 controller: sequences byte intake, padding, the 64 rounds,
// the chaining add and the eight digest beats.
// Depends on sha_pkg; commands sha_datapath through sha_cmd_t.
module sha_controller import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        in_has_byte,
    input  logic        in_msg_last,
    output logic        m_valid,
    input  logic        m_ready,
    input  sha_status_t status,
    output sha_cmd_t    cmd
);

    sha_state_t state_reg, state_next;
    sha_state_t ret_reg, ret_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] widx_reg, widx_next;

    logic block_full;

    assign block_full = (status.byte_pos == LAST_BYTE_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            round_reg <= '0;
            widx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            widx_reg  <= widx_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_next     = round_reg;
        widx_next      = widx_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        cmd            = '0;
        cmd.byte_sel   = SEL_IN;
        cmd.round      = round_reg;
        cmd.word_sel   = widx_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.shift_en = in_has_byte;
                    cmd.count_en = in_has_byte;
                    if (in_has_byte && block_full) begin
                        state_next     = S_COMP;
                        ret_next       = in_msg_last ? S_PAD80 : S_IDLE;
                        cmd.comp_start = 1'b1;
                        round_next     = '0;
                    end else if (in_msg_last) begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_80;
                state_next   = S_PADZ;
                if (block_full) begin
                    state_next     = S_COMP;
                    ret_next       = S_PADZ;
                    cmd.comp_start = 1'b1;
                    round_next     = '0;
                end
            end
            S_PADZ: begin
                // Zero fill up to the length field, spilling into a new block if needed.
                if (status.byte_pos == LEN_START_POS) begin
                    state_next = S_LEN;
                end else begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    if (block_full) begin
                        state_next     = S_COMP;
                        ret_next       = S_PADZ;
                        cmd.comp_start = 1'b1;
                        round_next     = '0;
                    end
                end
            end
            S_LEN: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_LEN;
                if (block_full) begin
                    state_next     = S_COMP;
                    ret_next       = S_OUT;
                    cmd.comp_start = 1'b1;
                    round_next     = '0;
                end
            end
            S_COMP: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                cmd.hash_add = 1'b1;
                state_next   = ret_reg;
                widx_next    = '0;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == LAST_WORD) begin
                        cmd.hash_init = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels open at once");

    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD) |-> (status.byte_pos == 6'd0))
        else $error("compression ran on a partial block");

    a_out_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (status.byte_pos == 6'd0))
        else $error("digest sent with bytes pending");

    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && widx_reg == LAST_WORD) |=> s_ready)
        else $error("input not reopened after final digest beat");
`endif

endmodule
